// ===== hw/rtl/ssm_pkg.sv =====
`default_nettype none

package ssm_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_STEPS   = 5;
    localparam int STEP_W      = $clog2(MAX_STEPS);

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] seconds_count;
        logic [31:0] stopwatch_millis;
    } tick_t;

    typedef struct packed {
        logic [7:0] digit_strobe;
        logic [7:0] segments;
    } disp_t;

    typedef enum logic [1:0] {
        MODE_CLOCK     = 2'd0,
        MODE_RING      = 2'd1,
        MODE_STOPWATCH = 2'd2,
        MODE_NONE      = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        DIG_SEC_ONES,
        DIG_SEC_TENS,
        DIG_MIN_ONES,
        DIG_MIN_TENS,
        DIG_MS_TENS,
        DIG_MS_HUNDREDS,
        DIG_MS_THOUSANDS,
        DIG_MS_TEN_THOUSANDS,
        DIG_RING_LOW,
        DIG_RING_HIGH
    } digit_sel_t;

    typedef struct packed {
        digit_sel_t  sel;
        logic [31:0] operand;
        logic [7:0]  strobe;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } back_state_t;

    function automatic logic [STEP_W-1:0] last_step_of(input digit_sel_t sel);
        logic [STEP_W-1:0] n;
        unique case (sel)
            DIG_SEC_ONES:         n = STEP_W'(0);
            DIG_SEC_TENS:         n = STEP_W'(1);
            DIG_MIN_ONES:         n = STEP_W'(2);
            DIG_MIN_TENS:         n = STEP_W'(3);
            DIG_MS_TENS:          n = STEP_W'(1);
            DIG_MS_HUNDREDS:      n = STEP_W'(2);
            DIG_MS_THOUSANDS:     n = STEP_W'(3);
            DIG_MS_TEN_THOUSANDS: n = STEP_W'(4);
            default:              n = STEP_W'(0);
        endcase
        return n;
    endfunction

    function automatic logic divides_by_six(input digit_sel_t sel,
                                            input logic [STEP_W-1:0] step);
        logic six;
        unique case (sel)
            DIG_SEC_TENS,
            DIG_MIN_ONES:         six = (step == STEP_W'(1));
            DIG_MIN_TENS:         six = (step == STEP_W'(1)) || (step == STEP_W'(3));
            DIG_MS_TEN_THOUSANDS: six = (step == STEP_W'(4));
            default:              six = 1'b0;
        endcase
        return six;
    endfunction

    function automatic logic [7:0] font_of(input logic [3:0] digit);
        logic [7:0] f;
        unique case (digit)
            4'd0:    f = 8'hc0;
            4'd1:    f = 8'hf9;
            4'd2:    f = 8'ha4;
            4'd3:    f = 8'hb0;
            4'd4:    f = 8'h99;
            4'd5:    f = 8'h92;
            4'd6:    f = 8'h82;
            4'd7:    f = 8'hd8;
            4'd8:    f = 8'h80;
            4'd9:    f = 8'h98;
            default: f = 8'hff;
        endcase
        return f;
    endfunction

    function automatic logic [7:0] ring_low_of(input logic [2:0] idx);
        logic [7:0] f;
        unique case (idx)
            3'd0:    f = 8'hff;
            3'd1:    f = 8'hfe;
            3'd2:    f = 8'hfd;
            3'd3:    f = 8'hfb;
            3'd4:    f = 8'hf7;
            default: f = 8'hff;
        endcase
        return f;
    endfunction

    function automatic logic [7:0] ring_high_of(input logic [2:0] idx);
        logic [7:0] f;
        unique case (idx)
            3'd0:    f = 8'hfe;
            3'd5:    f = 8'hf7;
            3'd6:    f = 8'hef;
            3'd7:    f = 8'hdf;
            default: f = 8'hff;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ssm_front.sv =====
`default_nettype none

module ssm_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   tick_valid,
    output logic                        tick_stall,
    input  wire ssm_pkg::tick_t         tick_data,
    input  wire ssm_pkg::queue_status_t q_status,
    output logic                        push,
    output ssm_pkg::job_t               push_data
);
    import ssm_pkg::*;

    logic [1:0] scan_reg [3];
    logic [1:0] pos;
    logic       accept;
    mode_t      mode;

    assign mode       = mode_t'(tick_data.mode);
    assign tick_stall = q_status.full;
    assign accept     = tick_valid && !q_status.full;

    always_comb
    begin
        unique case (mode)
            MODE_CLOCK:     pos = scan_reg[0];
            MODE_RING:      pos = scan_reg[1];
            MODE_STOPWATCH: pos = scan_reg[2];
            default:        pos = 2'd0;
        endcase

        push              = accept && (mode != MODE_NONE);
        push_data.strobe  = 8'h80 >> pos;
        push_data.operand = (mode == MODE_STOPWATCH) ? tick_data.stopwatch_millis
                                                     : tick_data.seconds_count;

        if (mode == MODE_STOPWATCH)
        begin
            unique case (pos)
                2'd0:    push_data.sel = DIG_MS_TENS;
                2'd1:    push_data.sel = DIG_MS_HUNDREDS;
                2'd2:    push_data.sel = DIG_MS_THOUSANDS;
                default: push_data.sel = DIG_MS_TEN_THOUSANDS;
            endcase
        end
        else
        begin
            unique case (pos)
                2'd0:    push_data.sel = DIG_SEC_ONES;
                2'd1:    push_data.sel = DIG_SEC_TENS;
                2'd2:    push_data.sel = (mode == MODE_RING) ? DIG_RING_LOW : DIG_MIN_ONES;
                default: push_data.sel = (mode == MODE_RING) ? DIG_RING_HIGH : DIG_MIN_TENS;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg[0] <= 2'd0;
            scan_reg[1] <= 2'd0;
            scan_reg[2] <= 2'd0;
        end
        else if (accept)
        begin
            unique case (mode)
                MODE_CLOCK:     scan_reg[0] <= scan_reg[0] + 2'd1;
                MODE_RING:      scan_reg[1] <= scan_reg[1] + 2'd1;
                MODE_STOPWATCH: scan_reg[2] <= scan_reg[2] + 2'd1;
                default:        ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ssm_queue.sv =====
`default_nettype none

module ssm_queue #(
    parameter int DEPTH = ssm_pkg::QUEUE_DEPTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire ssm_pkg::job_t          push_data,
    input  wire logic                   pop,
    output ssm_pkg::job_t               pop_data,
    output ssm_pkg::queue_status_t      q_status
);
    import ssm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_data       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ssm_back.sv =====
`default_nettype none

module ssm_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ssm_pkg::queue_status_t q_status,
    input  wire ssm_pkg::job_t          pop_data,
    output logic                        pop,
    input  wire logic                   cathode,
    output logic                        disp_valid,
    input  wire logic                   disp_stall,
    output ssm_pkg::disp_t              disp_data
);
    import ssm_pkg::*;

    localparam logic [31:0] RECIP_TEN = 32'hcccc_cccd;
    localparam logic [31:0] RECIP_SIX = 32'haaaa_aaab;

    back_state_t       state_reg;
    back_state_t       state_next;
    job_t              job_reg;
    logic [31:0]       value_reg;
    logic [3:0]        digit_reg;
    logic [STEP_W-1:0] step_reg;
    logic              disp_valid_reg;
    disp_t             disp_reg;
    logic              load;
    logic              emit;
    logic              out_free;
    logic              by_six;
    logic [31:0]       recip;
    logic [63:0]       product;
    logic [31:0]       quotient;
    logic [31:0]       remainder;
    logic [7:0]        seg;

    assign out_free   = !disp_valid_reg || !disp_stall;
    assign disp_valid = disp_valid_reg;
    assign disp_data  = disp_reg;
    assign pop        = load;

    always_comb
    begin
        by_six   = divides_by_six(job_reg.sel, step_reg);
        recip    = by_six ? RECIP_SIX : RECIP_TEN;
        product  = 64'(value_reg) * 64'(recip);
        quotient = by_six ? {2'd0, product[63:34]} : {3'd0, product[63:35]};
        if (by_six)
        begin
            remainder = value_reg - ((quotient << 2) + (quotient << 1));
        end
        else
        begin
            remainder = value_reg - ((quotient << 3) + (quotient << 1));
        end

        unique case (job_reg.sel)
            DIG_RING_LOW:  seg = ring_low_of(job_reg.operand[2:0]);
            DIG_RING_HIGH: seg = ring_high_of(job_reg.operand[2:0]);
            default:       seg = font_of(digit_reg);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    load       = 1'b1;
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (step_reg == last_step_of(job_reg.sel))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (!q_status.empty)
                    begin
                        load       = 1'b1;
                        state_next = BK_RUN;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            step_reg       <= '0;
            disp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                step_reg <= '0;
            end
            else if (state_reg == BK_RUN)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (emit)
            begin
                disp_valid_reg <= 1'b1;
            end
            else if (!disp_stall)
            begin
                disp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg   <= pop_data;
            value_reg <= pop_data.operand;
        end
        else if (state_reg == BK_RUN)
        begin
            value_reg <= quotient;
            digit_reg <= remainder[3:0];
        end
        if (emit)
        begin
            disp_reg.digit_strobe <= job_reg.strobe ^ {8{cathode}};
            disp_reg.segments     <= seg ^ {8{cathode}};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/seven_segment_scan_modes_core.sv =====
// Four-digit seven-segment scan driver.
// The tick channel (tick_valid, tick_stall, tick_data) carries one scan tick per
// transfer: the mode, the seconds count and the stopwatch milliseconds. Each tick
// in modes 0 to 2 yields one transfer on the display channel (disp_valid,
// disp_stall, disp_data) with the digit strobe and the segment byte; a tick in
// mode 3 is taken and yields nothing. Each mode advances its own scan position.
// Accepted ticks wait in a two-entry queue. The back end divides the operand by ten
// or six once per cycle, one to five times depending on the digit, and keeps the
// last remainder as the digit; a ring digit instead takes its pattern from the low
// three bits of the seconds count. The back end works on one job at a time and
// loads the next queued job as it hands a result to the output register.
// The output register holds a result while disp_stall is high; the back end
// finishes the next digit meanwhile, and tick_stall rises once the queue fills.
// wr_en writes the cathode polarity from wr_data; with polarity set both output
// bytes are inverted. Reset clears the scan positions, the queue, the output
// valid and the polarity.
`default_nettype none

module seven_segment_scan_modes_core #(
    parameter int QUEUE_DEPTH = ssm_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            tick_valid,
    output logic                 tick_stall,
    input  wire ssm_pkg::tick_t  tick_data,
    output logic                 disp_valid,
    input  wire logic            disp_stall,
    output ssm_pkg::disp_t       disp_data,
    input  wire logic            wr_en,
    input  wire logic            wr_data
);
    import ssm_pkg::*;

    logic          cathode_reg;
    logic          q_push;
    logic          q_pop;
    job_t          q_push_data;
    job_t          q_pop_data;
    queue_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cathode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            cathode_reg <= wr_data;
        end
    end

    ssm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick_data  (tick_data),
        .q_status   (q_status),
        .push       (q_push),
        .push_data  (q_push_data)
    );

    ssm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .q_status  (q_status)
    );

    ssm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_data   (q_pop_data),
        .pop        (q_pop),
        .cathode    (cathode_reg),
        .disp_valid (disp_valid),
        .disp_stall (disp_stall),
        .disp_data  (disp_data)
    );

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !q_push)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue read while empty");

    a_strobe_shape: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid |-> ($onehot(disp_data.digit_strobe ^ {8{cathode_reg}})
            && (((disp_data.digit_strobe ^ {8{cathode_reg}}) & 8'h0f) == 8'h00)))
        else $error("digit strobe does not select exactly one digit");
`endif

endmodule

`default_nettype wire

// ===== test/seven_segment_scan_modes_core_tb.sv =====
`timescale 1ns / 1ps

module seven_segment_scan_modes_core_tb;
    import ssm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 40;
    localparam int RANDOM_TICKS = 410;

    logic  clk;
    logic  rst_n;
    logic  tick_valid;
    logic  tick_stall;
    tick_t tick_data;
    logic  disp_valid;
    logic  disp_stall;
    disp_t disp_data;
    logic  wr_en;
    logic  wr_data;

    disp_t       display_q [$];
    disp_t       oldest;
    logic [1:0]  scan_pos [0:2];
    logic        cathode_q;
    int          send_idle_pct;
    int          stall_pct;
    bit          failed;
    int unsigned cycle_count;

    seven_segment_scan_modes_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick_data  (tick_data),
        .disp_valid (disp_valid),
        .disp_stall (disp_stall),
        .disp_data  (disp_data),
        .wr_en      (wr_en),
        .wr_data    (wr_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] glyph(input logic [3:0] digit);
        logic [7:0] g;
        case (digit)
            4'd0:    g = 8'hc0;
            4'd1:    g = 8'hf9;
            4'd2:    g = 8'ha4;
            4'd3:    g = 8'hb0;
            4'd4:    g = 8'h99;
            4'd5:    g = 8'h92;
            4'd6:    g = 8'h82;
            4'd7:    g = 8'hd8;
            4'd8:    g = 8'h80;
            default: g = 8'h98;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] ring_third(input logic [2:0] phase);
        logic [7:0] g;
        case (phase)
            3'd1:    g = 8'hfe;
            3'd2:    g = 8'hfd;
            3'd3:    g = 8'hfb;
            3'd4:    g = 8'hf7;
            default: g = 8'hff;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] ring_fourth(input logic [2:0] phase);
        logic [7:0] g;
        case (phase)
            3'd0:    g = 8'hfe;
            3'd5:    g = 8'hf7;
            3'd6:    g = 8'hef;
            3'd7:    g = 8'hdf;
            default: g = 8'hff;
        endcase
        return g;
    endfunction

    function automatic bit predict_display(input tick_t t, output disp_t d);
        logic [1:0]  p;
        logic [31:0] s;
        logic [31:0] m;
        logic [31:0] dig;
        logic [7:0]  seg;
        d = '0;
        if (t.mode == MODE_NONE)
            return 1'b0;
        p = scan_pos[t.mode];
        s = t.seconds_count;
        m = t.stopwatch_millis;
        if (t.mode == MODE_STOPWATCH)
        begin
            case (p)
                2'd0:    dig = (m / 32'd10) % 32'd10;
                2'd1:    dig = (m / 32'd100) % 32'd10;
                2'd2:    dig = (m / 32'd1000) % 32'd10;
                default: dig = (m / 32'd10000) % 32'd6;
            endcase
            seg = glyph(dig[3:0]);
        end
        else if (p == 2'd0)
        begin
            dig = s % 32'd10;
            seg = glyph(dig[3:0]);
        end
        else if (p == 2'd1)
        begin
            dig = (s / 32'd10) % 32'd6;
            seg = glyph(dig[3:0]);
        end
        else if (t.mode == MODE_CLOCK)
        begin
            dig = (p == 2'd2) ? (s / 32'd60) % 32'd10 : (s / 32'd600) % 32'd6;
            seg = glyph(dig[3:0]);
        end
        else
        begin
            seg = (p == 2'd2) ? ring_third(s[2:0]) : ring_fourth(s[2:0]);
        end
        scan_pos[t.mode] = p + 2'd1;
        d.digit_strobe = 8'h80 >> p;
        d.segments = seg;
        if (cathode_q)
            d = ~d;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && disp_valid && !disp_stall)
        begin
            if (display_q.size() == 0)
            begin
                $display("%0t: unexpected display transfer %h", $time, disp_data);
                failed = 1'b1;
            end
            else
            begin
                oldest = display_q.pop_front();
                if (disp_data.digit_strobe !== oldest.digit_strobe)
                begin
                    $display("%0t: digit_strobe expected %h actual %h", $time,
                             oldest.digit_strobe, disp_data.digit_strobe);
                    failed = 1'b1;
                end
                if (disp_data.segments !== oldest.segments)
                begin
                    $display("%0t: segments expected %h actual %h", $time,
                             oldest.segments, disp_data.segments);
                    failed = 1'b1;
                end
            end
        end
        disp_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_tick(input logic [1:0] mode, input logic [31:0] secs,
                             input logic [31:0] millis);
        tick_t t;
        disp_t d;
        int    gap;
        t.mode = mode;
        t.seconds_count = secs;
        t.stopwatch_millis = millis;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_data <= t;
        do
            @(posedge clk);
        while (tick_stall);
        if (predict_display(t, d))
            display_q.push_back(d);
    endtask

    task automatic hold_until_empty();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (display_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic drain();
        hold_until_empty();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_polarity(input logic v);
        wr_en <= 1'b1;
        wr_data <= v;
        @(posedge clk);
        wr_en <= 1'b0;
        cathode_q = v;
    endtask

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 7199);
            1:       return 32'hffff_ffff - $urandom_range(0, 999);
            2:       return $urandom_range(0, 99999);
            3:       return $urandom_range(0, 1000) * 32'd600 - $urandom_range(0, 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_digit_extremes();
        send_tick(MODE_CLOCK, 32'hffff_ffff, 32'd0);
        send_tick(MODE_CLOCK, 32'd0, 32'hffff_ffff);
        send_tick(MODE_CLOCK, 32'd3599, 32'd0);
        send_tick(MODE_CLOCK, 32'hffff_ffff, 32'd0);
        send_tick(MODE_RING, 32'd7, 32'd0);
        send_tick(MODE_RING, 32'd5, 32'd0);
        send_tick(MODE_RING, 32'd0, 32'd0);
        send_tick(MODE_RING, 32'hffff_ffff, 32'd0);
        send_tick(MODE_STOPWATCH, 32'd0, 32'd0);
        send_tick(MODE_STOPWATCH, 32'hffff_ffff, 32'hffff_ffff);
        send_tick(MODE_STOPWATCH, 32'd0, 32'd59999);
        send_tick(MODE_STOPWATCH, 32'd0, 32'd59999);
        drain();
    endtask

    task automatic test_no_action_mode();
        send_tick(MODE_NONE, 32'd0, 32'd0);
        send_tick(MODE_NONE, 32'hffff_ffff, 32'hffff_ffff);
        send_tick(MODE_CLOCK, 32'd1234, 32'hffff_ffff);
        drain();
    endtask

    task automatic test_mode_interleave();
        send_tick(MODE_CLOCK, 32'd754, 32'd12345);
        send_tick(MODE_RING, 32'd43, 32'd12345);
        send_tick(MODE_STOPWATCH, 32'd43, 32'd98765);
        send_tick(MODE_CLOCK, 32'd2999, 32'd0);
        send_tick(MODE_RING, 32'd46, 32'd0);
        drain();
    endtask

    task automatic test_cathode_polarity();
        set_polarity(1'b1);
        send_tick(MODE_CLOCK, 32'd3599, 32'd0);
        send_tick(MODE_RING, 32'd6, 32'd0);
        send_tick(MODE_NONE, 32'd6, 32'd500);
        send_tick(MODE_STOPWATCH, 32'd0, 32'd45678);
        drain();
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input logic pol);
        int          counted;
        int          burst;
        int          k;
        logic [1:0]  mode;
        logic [31:0] secs;
        logic [31:0] millis;
        logic [31:0] step;
        set_polarity(pol);
        send_idle_pct = idle;
        stall_pct = stall;
        counted = 0;
        while (counted < RANDOM_TICKS)
        begin
            if ($urandom_range(0, 99) == 0)
                hold_until_empty();
            if ($urandom_range(0, 9) < 7)
            begin
                mode = 2'($urandom_range(0, 2));
                secs = pick_count();
                millis = pick_count();
                step = $urandom_range(1, 997);
                burst = $urandom_range(4, 12);
                for (k = 0; k < burst; k++)
                begin
                    send_tick(mode, secs + k, millis + k * step);
                    counted++;
                end
            end
            else
            begin
                mode = 2'($urandom_range(0, 3));
                send_tick(mode, $urandom, pick_count());
                if (mode != MODE_NONE)
                    counted++;
            end
        end
        drain();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        tick_valid <= 1'b0;
        tick_data <= '0;
        disp_stall <= 1'b0;
        wr_en <= 1'b0;
        wr_data <= 1'b0;
        cycle_count = 0;
        failed = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        cathode_q = 1'b0;
        scan_pos[0] = 2'd0;
        scan_pos[1] = 2'd0;
        scan_pos[2] = 2'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_polarity(1'b0);

        test_digit_extremes();
        test_no_action_mode();
        test_mode_interleave();
        test_cathode_polarity();
        test_random_traffic(0, 0, 1'b1);
        test_random_traffic(62, 0, 1'b0);
        test_random_traffic(0, 62, 1'b1);
        test_random_traffic(31, 31, 1'b0);

        if (!failed && display_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== seven_segment_scan_modes_core.f =====
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_front.sv
hw/rtl/ssm_queue.sv
hw/rtl/ssm_back.sv
hw/rtl/seven_segment_scan_modes_core.sv
test/seven_segment_scan_modes_core_tb.sv
